### hw/rtl/uvs_pkg.sv
// uvs_pkg: shared types, constants and helper functions of the uv sphere generator
// depends on nothing; imported by every module under hw/rtl
package uvs_pkg;

    localparam int unsigned CFG_W         = 7;
    localparam logic [6:0]  MAX_DIVISIONS = 7'd64;
    localparam logic [6:0]  SECTOR_MIN    = 7'd3;
    localparam logic [6:0]  STACK_MIN     = 7'd2;
    localparam logic [6:0]  SECTOR_RESET  = 7'd10;
    localparam logic [6:0]  STACK_RESET   = 7'd10;

    // divider: floor(a * 2^36 / d) for a <= d, four quotient bits per stage
    localparam int unsigned DIV_FRAC_BITS = 36;
    localparam int unsigned DIV_STEPS     = 4;
    localparam int unsigned DIV_STAGES    = DIV_FRAC_BITS / DIV_STEPS;
    localparam int unsigned QUO_W         = DIV_FRAC_BITS + 1;

    // cordic in q2.30 with guard bits
    localparam int unsigned CORDIC_STEPS = 16;
    localparam int unsigned CORDIC_W     = 34;
    localparam int unsigned CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam logic signed [CORDIC_W-1:0] CORDIC_START = 34'sd652032874;

    // accept register to queue write
    localparam int unsigned TEX_LAT   = CORDIC_LAT + 2;
    localparam int unsigned FRONT_LAT = DIV_STAGES + 1 + TEX_LAT;

    localparam int unsigned IDX_W = 13;

    typedef enum logic [1:0] {
        KIND_VERTEX   = 2'd0,
        KIND_TRIANGLE = 2'd1,
        KIND_ERROR    = 2'd2
    } kind_t;

    typedef enum logic {
        REG_SECTOR_COUNT = 1'b0,
        REG_STACK_COUNT  = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        STEP_FIRST,
        STEP_TRI_A,
        STEP_TRI_B
    } step_t;

    typedef struct packed {
        logic             err;
        logic             t1;
        logic             t2;
        logic [IDX_W-1:0] k1;
        logic [IDX_W-1:0] k2;
    } side_t;

    typedef struct packed {
        side_t              side;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
    } entry_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
        logic [IDX_W-1:0]   corner_a;
        logic [IDX_W-1:0]   corner_b;
        logic [IDX_W-1:0]   corner_c;
        logic               last;
    } result_t;

    // arctangent per step in units of 2^-32 turn
    function automatic logic signed [CORDIC_W-1:0] atan_turn(input int unsigned k);
        logic signed [CORDIC_W-1:0] a;
        case (k)
            0:       a = 34'sd536870912;
            1:       a = 34'sd316933406;
            2:       a = 34'sd167458907;
            3:       a = 34'sd85004756;
            4:       a = 34'sd42667331;
            5:       a = 34'sd21354465;
            6:       a = 34'sd10679838;
            7:       a = 34'sd5340245;
            8:       a = 34'sd2670163;
            9:       a = 34'sd1335087;
            10:      a = 34'sd667544;
            11:      a = 34'sd333772;
            12:      a = 34'sd166886;
            13:      a = 34'sd83443;
            14:      a = 34'sd41722;
            15:      a = 34'sd20861;
            default: a = '0;
        endcase
        return a;
    endfunction

    // shift with the magnitude truncated toward zero
    function automatic logic signed [CORDIC_W-1:0] trunc_shift(
        input logic signed [CORDIC_W-1:0] v,
        input int unsigned                k
    );
        logic [CORDIC_W-1:0] mag;
        mag = v[CORDIC_W-1] ? CORDIC_W'(-v) : CORDIC_W'(v);
        mag = mag >> k;
        return v[CORDIC_W-1] ? -signed'(mag) : signed'(mag);
    endfunction

    // round half away from zero by k bits, saturate to 16 bits
    function automatic logic signed [15:0] round_sat(
        input logic signed [63:0] v,
        input int unsigned        k
    );
        logic [63:0] mag;
        logic [63:0] m;
        mag = v[63] ? 64'(-v) : 64'(v);
        m   = (mag + (64'd1 << (k - 1))) >> k;
        if (v[63])
            return (m >= 64'd32768) ? 16'sh8000 : signed'(16'(64'd0 - m));
        else
            return (m > 64'd32767) ? 16'sh7fff : signed'(16'(m));
    endfunction

endpackage

### hw/rtl/uvs_div.sv
// uvs_div: pipelined restoring divider, floor(num * 2^36 / den)
// depends on uvs_pkg
module uvs_div
    import uvs_pkg::*;
(
    input  logic             clk,
    input  logic [CFG_W-1:0] num,
    input  logic [CFG_W-1:0] den,
    output logic [QUO_W-1:0] quo
);

    logic [CFG_W-1:0] rem_reg  [DIV_STAGES];
    logic [QUO_W-1:0] quo_reg  [DIV_STAGES];
    logic [CFG_W-1:0] den_reg  [DIV_STAGES];
    logic [CFG_W-1:0] rem_next [DIV_STAGES];
    logic [QUO_W-1:0] quo_next [DIV_STAGES];
    logic [CFG_W-1:0] den_next [DIV_STAGES];

    always_comb
    begin
        logic [CFG_W-1:0] rem;
        logic [QUO_W-1:0] q;
        logic [CFG_W-1:0] d;
        logic [CFG_W:0]   dbl;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                d = den;
                // integer bit first
                if (num >= den)
                begin
                    rem = num - den;
                    q   = QUO_W'(1);
                end
                else
                begin
                    rem = num;
                    q   = '0;
                end
            end
            else
            begin
                d   = den_reg[s-1];
                rem = rem_reg[s-1];
                q   = quo_reg[s-1];
            end
            for (int b = 0; b < DIV_STEPS; b++)
            begin
                dbl = {rem, 1'b0};
                if (dbl >= {1'b0, d})
                begin
                    rem = CFG_W'(dbl - {1'b0, d});
                    q   = {q[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem = dbl[CFG_W-1:0];
                    q   = {q[QUO_W-2:0], 1'b0};
                end
            end
            rem_next[s] = rem;
            quo_next[s] = q;
            den_next[s] = d;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            rem_reg[s] <= rem_next[s];
            quo_reg[s] <= quo_next[s];
            den_reg[s] <= den_next[s];
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];

endmodule

### hw/rtl/uvs_cordic.sv
// uvs_cordic: pipelined sine and cosine of a 32-bit phase, q2.30 results
// depends on uvs_pkg
module uvs_cordic
    import uvs_pkg::*;
(
    input  logic               clk,
    input  logic [31:0]        phase,
    output logic signed [31:0] cos_val,
    output logic signed [31:0] sin_val
);

    logic [1:0]                 q_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] y_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] r_reg [CORDIC_STEPS+1];

    logic [31:0] ph_round;
    logic [1:0]  quad;
    logic [31:0] resid;

    // nearest quadrant and signed residual
    assign ph_round = phase + 32'h2000_0000;
    assign quad     = ph_round[31:30];
    assign resid    = phase - {quad, 30'd0};

    always_ff @(posedge clk)
    begin
        q_reg[0] <= quad;
        x_reg[0] <= CORDIC_START;
        y_reg[0] <= '0;
        r_reg[0] <= signed'({{(CORDIC_W-32){resid[31]}}, resid});
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_step
        logic signed [CORDIC_W-1:0] xs;
        logic signed [CORDIC_W-1:0] ys;
        assign xs = trunc_shift(x_reg[k], k);
        assign ys = trunc_shift(y_reg[k], k);

        always_ff @(posedge clk)
        begin
            q_reg[k+1] <= q_reg[k];
            if (!r_reg[k][CORDIC_W-1])
            begin
                x_reg[k+1] <= x_reg[k] - ys;
                y_reg[k+1] <= y_reg[k] + xs;
                r_reg[k+1] <= r_reg[k] - atan_turn(k);
            end
            else
            begin
                x_reg[k+1] <= x_reg[k] + ys;
                y_reg[k+1] <= y_reg[k] - xs;
                r_reg[k+1] <= r_reg[k] + atan_turn(k);
            end
        end
    end

    logic signed [CORDIC_W-1:0] xf;
    logic signed [CORDIC_W-1:0] yf;
    logic signed [CORDIC_W-1:0] c_next;
    logic signed [CORDIC_W-1:0] s_next;

    assign xf = x_reg[CORDIC_STEPS];
    assign yf = y_reg[CORDIC_STEPS];

    always_comb
    begin
        case (q_reg[CORDIC_STEPS])
            2'd0:
            begin
                c_next = xf;
                s_next = yf;
            end
            2'd1:
            begin
                c_next = -yf;
                s_next = xf;
            end
            2'd2:
            begin
                c_next = -xf;
                s_next = -yf;
            end
            default:
            begin
                c_next = yf;
                s_next = -xf;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cos_val <= signed'(c_next[31:0]);
        sin_val <= signed'(s_next[31:0]);
    end

endmodule

### hw/rtl/uvs_front.sv
// uvs_front: takes grid points, classifies them and computes vertex data
// depends on uvs_pkg, uvs_div and uvs_cordic
module uvs_front
    import uvs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic [CFG_W-1:0] stack_index,
    input  logic [CFG_W-1:0] sector_index,
    input  logic [CFG_W-1:0] sector_count,
    input  logic [CFG_W-1:0] stack_count,
    output logic             out_valid,
    output entry_t           out_entry
);

    // classification at the accepting edge
    side_t       side_next;
    logic        in_cell;
    logic [14:0] k1_full;

    always_comb
    begin
        in_cell        = (stack_index < stack_count) && (sector_index < sector_count);
        k1_full        = 15'(stack_index * {1'b0, sector_count} + {8'd0, sector_index})
                         + 15'(stack_index * 8'd0);
        side_next.err  = (stack_index > stack_count) || (sector_index > sector_count);
        side_next.t1   = in_cell && (stack_index != 7'd0);
        side_next.t2   = in_cell && (stack_index != stack_count - 7'd1);
        side_next.k1   = IDX_W'(k1_full + {8'd0, stack_index});
        side_next.k2   = IDX_W'(k1_full + {8'd0, stack_index}
                         + {8'd0, sector_count} + 15'd1);
    end

    logic             a_vld_reg;
    side_t            a_side_reg;
    logic [CFG_W-1:0] a_i_reg;
    logic [CFG_W-1:0] a_j_reg;
    logic [CFG_W-1:0] a_s_reg;
    logic [CFG_W-1:0] a_t_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else
            a_vld_reg <= take;
    end

    always_ff @(posedge clk)
    begin
        a_side_reg <= side_next;
        a_i_reg    <= stack_index;
        a_j_reg    <= sector_index;
        a_s_reg    <= sector_count;
        a_t_reg    <= stack_count;
    end

    // j / sectors and i / stacks
    logic [QUO_W-1:0] quo_lon;
    logic [QUO_W-1:0] quo_lat;

    uvs_div u_div_lon (
        .clk (clk),
        .num (a_j_reg),
        .den (a_s_reg),
        .quo (quo_lon)
    );

    uvs_div u_div_lat (
        .clk (clk),
        .num (a_i_reg),
        .den (a_t_reg),
        .quo (quo_lat)
    );

    // phases and texture coordinates, rounded half up
    logic [33:0] lon_sum;
    logic [32:0] lat_sum;
    logic [17:0] u_sum;
    logic [17:0] v_sum;
    logic [31:0] lon_reg;
    logic [31:0] lat_reg;
    logic [16:0] u_reg;
    logic [16:0] v_reg;

    assign lon_sum = quo_lon[QUO_W-1:3] + 34'd1;
    assign lat_sum = quo_lat[QUO_W-1:4] + 33'd1;
    assign u_sum   = quo_lon[QUO_W-1:19] + 18'd1;
    assign v_sum   = quo_lat[QUO_W-1:19] + 18'd1;

    always_ff @(posedge clk)
    begin
        lon_reg <= lon_sum[32:1];
        lat_reg <= 32'h4000_0000 - lat_sum[32:1];
        u_reg   <= u_sum[17:1];
        v_reg   <= v_sum[17:1];
    end

    logic signed [31:0] clat;
    logic signed [31:0] slat;
    logic signed [31:0] clon;
    logic signed [31:0] slon;

    uvs_cordic u_cordic_lat (
        .clk     (clk),
        .phase   (lat_reg),
        .cos_val (clat),
        .sin_val (slat)
    );

    uvs_cordic u_cordic_lon (
        .clk     (clk),
        .phase   (lon_reg),
        .cos_val (clon),
        .sin_val (slon)
    );

    // products, then rounding
    logic signed [63:0] px_prod_reg;
    logic signed [63:0] py_prod_reg;
    logic signed [31:0] slat_reg;
    logic signed [15:0] pos_x_reg;
    logic signed [15:0] pos_y_reg;
    logic signed [15:0] pos_z_reg;

    always_ff @(posedge clk)
    begin
        px_prod_reg <= clat * clon;
        py_prod_reg <= clat * slon;
        slat_reg    <= slat;
        pos_x_reg   <= round_sat(px_prod_reg, 45);
        pos_y_reg   <= round_sat(py_prod_reg, 45);
        pos_z_reg   <= round_sat(64'(slat_reg), 15);
    end

    // side information and texture travel alongside the arithmetic
    logic [FRONT_LAT-1:0] vld_reg;
    side_t                side_reg [FRONT_LAT];
    logic [16:0]          tu_reg   [TEX_LAT];
    logic [16:0]          tv_reg   [TEX_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[FRONT_LAT-2:0], a_vld_reg};
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= a_side_reg;
        for (int k = 1; k < FRONT_LAT; k++)
            side_reg[k] <= side_reg[k-1];
        tu_reg[0] <= u_reg;
        tv_reg[0] <= v_reg;
        for (int k = 1; k < TEX_LAT; k++)
        begin
            tu_reg[k] <= tu_reg[k-1];
            tv_reg[k] <= tv_reg[k-1];
        end
    end

    assign out_valid       = vld_reg[FRONT_LAT-1];
    assign out_entry.side  = side_reg[FRONT_LAT-1];
    assign out_entry.pos_x = pos_x_reg;
    assign out_entry.pos_y = pos_y_reg;
    assign out_entry.pos_z = pos_z_reg;
    assign out_entry.tex_u = tu_reg[TEX_LAT-1];
    assign out_entry.tex_v = tv_reg[TEX_LAT-1];

endmodule

### hw/rtl/uvs_queue.sv
// uvs_queue: small first-in first-out queue between front and back
// depends on uvs_pkg
module uvs_queue
    import uvs_pkg::*;
#(
    parameter int unsigned DEPTH = 32
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t head,
    output logic   not_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (cnt_reg != '0);

endmodule

### hw/rtl/uvs_back.sv
// uvs_back: turns each queued point into vertex, triangle or error results
// depends on uvs_pkg
module uvs_back
    import uvs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  entry_t  head,
    input  logic    has_item,
    output logic    pop,
    output logic    strobe,
    output result_t res
);

    step_t   step_reg;
    step_t   step_next;
    result_t res_next;
    result_t res_reg;
    logic    strobe_reg;

    // next step
    always_comb
    begin
        step_next = step_reg;
        unique case (step_reg)
            STEP_FIRST:
            begin
                if (has_item && !head.side.err)
                begin
                    if (head.side.t1)
                        step_next = STEP_TRI_A;
                    else if (head.side.t2)
                        step_next = STEP_TRI_B;
                end
            end
            STEP_TRI_A:
            begin
                step_next = head.side.t2 ? STEP_TRI_B : STEP_FIRST;
            end
            STEP_TRI_B:
            begin
                step_next = STEP_FIRST;
            end
            default:
            begin
                step_next = STEP_FIRST;
            end
        endcase
    end

    // result of the current step
    always_comb
    begin
        res_next      = '0;
        res_next.kind = KIND_VERTEX;
        unique case (step_reg)
            STEP_FIRST:
            begin
                if (head.side.err)
                begin
                    res_next.kind = KIND_ERROR;
                    res_next.last = 1'b1;
                end
                else
                begin
                    res_next.pos_x = head.pos_x;
                    res_next.pos_y = head.pos_y;
                    res_next.pos_z = head.pos_z;
                    res_next.tex_u = head.tex_u;
                    res_next.tex_v = head.tex_v;
                    res_next.last  = !(head.side.t1 || head.side.t2);
                end
            end
            STEP_TRI_A:
            begin
                res_next.kind     = KIND_TRIANGLE;
                res_next.corner_a = head.side.k1;
                res_next.corner_b = head.side.k2;
                res_next.corner_c = head.side.k1 + 1'b1;
                res_next.last     = !head.side.t2;
            end
            STEP_TRI_B:
            begin
                res_next.kind     = KIND_TRIANGLE;
                res_next.corner_a = head.side.k1 + 1'b1;
                res_next.corner_b = head.side.k2;
                res_next.corner_c = head.side.k2 + 1'b1;
                res_next.last     = 1'b1;
            end
            default:
            begin
                res_next.last = 1'b1;
            end
        endcase
        pop = has_item && res_next.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= STEP_FIRST;
            strobe_reg <= 1'b0;
        end
        else
        begin
            step_reg   <= has_item ? step_next : STEP_FIRST;
            strobe_reg <= has_item;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign strobe = strobe_reg;
    assign res    = res_reg;

endmodule

### hw/rtl/uv_sphere_mesh_generator_top.sv
// throughput: one result per cycle on the result port while the queue is not empty, and
// one to three results per point; the divider and cordic pipelines take a new point every
// cycle, and a point stalls only when QUEUE_DEPTH points are in flight and none is popped,
// a limit set by the queue between front and back
// reset: asynchronous, active low; counts return to 10 and all in-flight work is dropped
// uv_sphere_mesh_generator_top: config registers, in-flight credit and the front/back split
// depends on uvs_pkg, uvs_front, uvs_queue and uvs_back
module uv_sphere_mesh_generator_top
    import uvs_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,

    // apb configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    // command side
    input  logic               start,
    output logic               busy,
    input  logic [6:0]         stack_index,
    input  logic [6:0]         sector_index,

    // result side, one transfer per strobe cycle
    output logic               strobe,
    output logic [1:0]         kind,
    output logic signed [15:0] pos_x,
    output logic signed [15:0] pos_y,
    output logic signed [15:0] pos_z,
    output logic [16:0]        tex_u,
    output logic [16:0]        tex_v,
    output logic [12:0]        corner_a,
    output logic [12:0]        corner_b,
    output logic [12:0]        corner_c,
    output logic               last
);

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    // configuration registers, clamped on write
    logic [CFG_W-1:0] sector_count_reg;
    logic [CFG_W-1:0] stack_count_reg;
    logic [CFG_W-1:0] sector_count_next;
    logic [CFG_W-1:0] stack_count_next;
    logic             cfg_wr;
    reg_idx_t         cfg_idx;
    logic [CFG_W-1:0] wval;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[2]);
    assign wval    = pwdata[CFG_W-1:0];

    always_comb
    begin
        sector_count_next = sector_count_reg;
        stack_count_next  = stack_count_reg;
        if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_SECTOR_COUNT:
                begin
                    if (wval < SECTOR_MIN)
                        sector_count_next = SECTOR_MIN;
                    else if (wval > MAX_DIVISIONS)
                        sector_count_next = MAX_DIVISIONS;
                    else
                        sector_count_next = wval;
                end
                REG_STACK_COUNT:
                begin
                    if (wval < STACK_MIN)
                        stack_count_next = STACK_MIN;
                    else if (wval > MAX_DIVISIONS)
                        stack_count_next = MAX_DIVISIONS;
                    else
                        stack_count_next = wval;
                end
                default:
                begin
                    sector_count_next = sector_count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sector_count_reg <= SECTOR_RESET;
            stack_count_reg  <= STACK_RESET;
        end
        else
        begin
            sector_count_reg <= sector_count_next;
            stack_count_reg  <= stack_count_next;
        end
    end

    assign prdata = (cfg_idx == REG_STACK_COUNT) ? {25'd0, stack_count_reg}
                                                 : {25'd0, sector_count_reg};

    // credit: points accepted but not yet fully emitted never exceed the queue depth,
    // so the front pipeline never has to stall
    logic             take;
    logic             pop;
    logic [CNT_W-1:0] inflight_reg;
    logic [CNT_W-1:0] inflight_next;

    assign busy = (inflight_reg == CNT_W'(QUEUE_DEPTH)) && !pop;
    assign take = start && !busy;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (take && !pop)
            inflight_next = inflight_reg + 1'b1;
        else if (pop && !take)
            inflight_next = inflight_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    // front: classify and compute vertex data
    logic   fr_valid;
    entry_t fr_entry;

    uvs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .stack_index  (stack_index),
        .sector_index (sector_index),
        .sector_count (sector_count_reg),
        .stack_count  (stack_count_reg),
        .out_valid    (fr_valid),
        .out_entry    (fr_entry)
    );

    // queue between the two halves
    entry_t q_head;
    logic   q_not_empty;

    uvs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fr_valid),
        .push_entry (fr_entry),
        .pop        (pop),
        .head       (q_head),
        .not_empty  (q_not_empty)
    );

    // back: one result per cycle from the queue head while the queue is not empty
    result_t res;

    uvs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .has_item (q_not_empty),
        .pop      (pop),
        .strobe   (strobe),
        .res      (res)
    );

    assign kind     = res.kind;
    assign pos_x    = res.pos_x;
    assign pos_y    = res.pos_y;
    assign pos_z    = res.pos_z;
    assign tex_u    = res.tex_u;
    assign tex_v    = res.tex_v;
    assign corner_a = res.corner_a;
    assign corner_b = res.corner_b;
    assign corner_c = res.corner_c;
    assign last     = res.last;

    // credit never overruns the queue
    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("in-flight count above queue depth");

    // an error result is always the only one of its point
    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (kind == KIND_ERROR) |-> last)
        else $error("error result without last");

    // a pop only happens with an item present
    a_pop_item: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_not_empty)
        else $error("pop from empty queue");

endmodule
